[rtl/lkw_pkg.sv]
// Shared types and constants for the link keepalive watchdog.
// Used by lkw_regs, lkw_step and link_keepalive_watchdog; no dependencies.
package lkw_pkg;

    localparam int TIME_BITS     = 48;
    localparam int SEC_BITS      = 16;
    localparam int MS_PER_SEC    = 1000;
    localparam int MS_BITS       = SEC_BITS + 10;
    localparam int MODE_BITS     = 2;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    localparam logic [REG_IDX_BITS-1:0] REG_KEEPALIVE_MODE    = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PING_ON_CONNECT   = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_FORCE_RECONNECT   = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_PING_INTERVAL_SEC = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_PONG_GRACE_SEC    = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_STALE_RX_SEC      = 3'd5;

    localparam logic [1:0] REASON_ACK_TIMEOUT = 2'd0;
    localparam logic [1:0] REASON_RX_STALE    = 2'd1;
    localparam logic [1:0] REASON_SEND_FAILED = 2'd2;

    typedef logic [TIME_BITS-1:0] stamp_t;
    typedef logic [MS_BITS-1:0]   ms_t;

    typedef struct packed {
        logic   connected;
        stamp_t now_ms;
        stamp_t last_rx_ms;
        stamp_t last_tx_ms;
        stamp_t last_ping_ms;
        stamp_t last_pong_ms;
        logic   send_ok;
        stamp_t sent_ping_ms;
    } tick_t;

    typedef struct packed {
        logic       ping_request;
        logic       ping_failed;
        logic       stale_event;
        logic [1:0] stale_reason;
    } result_t;

    typedef struct packed {
        logic [MODE_BITS-1:0] keepalive_mode;
        logic                 connect_ping_en;
        logic                 force_reconnect;
        ms_t                  interval_ms;
        ms_t                  ack_window_ms;
        ms_t                  stale_ms;
    } cfg_t;

    typedef struct packed {
        logic   connect_ping_done;
        logic   awaiting_ack;
        logic   stale_reported;
        stamp_t expected_ping_stamp;
    } state_t;

endpackage

[rtl/lkw_regs.sv]
// APB configuration registers for the link keepalive watchdog.
// Holds raw second values for read-back and their millisecond limits; uses lkw_pkg.
module lkw_regs
    import lkw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    logic [MODE_BITS-1:0]    mode_reg;
    logic                    connect_ping_en_reg;
    logic                    force_reconnect_reg;
    logic [SEC_BITS-1:0]     interval_sec_reg;
    logic [SEC_BITS-1:0]     grace_sec_reg;
    logic [SEC_BITS-1:0]     stale_sec_reg;
    ms_t                     interval_ms_reg;
    ms_t                     ack_window_ms_reg;
    ms_t                     stale_ms_reg;
    logic                    wr_en;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic [SEC_BITS-1:0]     wr_sec;
    logic [SEC_BITS-1:0]     wr_sec_fixed;
    ms_t                     wr_ms;

    assign pready       = 1'b1;
    assign wr_en        = psel && penable && pwrite;
    assign reg_idx      = paddr[APB_ADDR_BITS-1:2];
    assign wr_sec       = pwdata[SEC_BITS-1:0];
    assign wr_sec_fixed = (wr_sec == '0) ? SEC_BITS'(1) : wr_sec;
    assign wr_ms        = MS_BITS'(wr_sec_fixed) * MS_BITS'(MS_PER_SEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= '0;
            connect_ping_en_reg <= 1'b0;
            force_reconnect_reg <= 1'b0;
            interval_sec_reg    <= SEC_BITS'(1);
            grace_sec_reg       <= SEC_BITS'(1);
            stale_sec_reg       <= SEC_BITS'(1);
            interval_ms_reg     <= MS_BITS'(MS_PER_SEC);
            ack_window_ms_reg   <= MS_BITS'(MS_PER_SEC);
            stale_ms_reg        <= MS_BITS'(MS_PER_SEC);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_KEEPALIVE_MODE:    mode_reg <= pwdata[MODE_BITS-1:0];
                REG_PING_ON_CONNECT:   connect_ping_en_reg <= pwdata[0];
                REG_FORCE_RECONNECT:   force_reconnect_reg <= pwdata[0];
                REG_PING_INTERVAL_SEC:
                begin
                    interval_sec_reg <= wr_sec;
                    interval_ms_reg  <= wr_ms;
                end
                REG_PONG_GRACE_SEC:
                begin
                    grace_sec_reg     <= wr_sec;
                    ack_window_ms_reg <= wr_ms;
                end
                REG_STALE_RX_SEC:
                begin
                    stale_sec_reg <= wr_sec;
                    stale_ms_reg  <= wr_ms;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KEEPALIVE_MODE:    prdata = APB_DATA_BITS'(mode_reg);
            REG_PING_ON_CONNECT:   prdata = APB_DATA_BITS'(connect_ping_en_reg);
            REG_FORCE_RECONNECT:   prdata = APB_DATA_BITS'(force_reconnect_reg);
            REG_PING_INTERVAL_SEC: prdata = APB_DATA_BITS'(interval_sec_reg);
            REG_PONG_GRACE_SEC:    prdata = APB_DATA_BITS'(grace_sec_reg);
            REG_STALE_RX_SEC:      prdata = APB_DATA_BITS'(stale_sec_reg);
            default:               prdata = '0;
        endcase
    end

    assign cfg.keepalive_mode  = mode_reg;
    assign cfg.connect_ping_en = connect_ping_en_reg;
    assign cfg.force_reconnect = force_reconnect_reg;
    assign cfg.interval_ms     = interval_ms_reg;
    assign cfg.ack_window_ms   = ack_window_ms_reg;
    assign cfg.stale_ms        = stale_ms_reg;

endmodule

[rtl/lkw_step.sv]
// Per-tick decision logic of the link keepalive watchdog: result and next state.
// Purely combinational; uses lkw_pkg.
module lkw_step
    import lkw_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  st,
    input  tick_t   tick,
    output result_t res,
    output state_t  st_next
);

    function automatic logic elapsed(stamp_t now, stamp_t since, ms_t limit);
        logic [TIME_BITS:0] diff;
        diff = {1'b0, now} - {1'b0, since};
        return !diff[TIME_BITS] && (diff[TIME_BITS-1:0] >= TIME_BITS'(limit));
    endfunction

    logic   enabled;
    logic   want_ping;
    stamp_t idle_base;
    stamp_t ack_seen;
    stamp_t new_stamp;
    logic   idle_hit;
    logic   ack_late;
    logic   rx_stale;

    assign enabled   = cfg.keepalive_mode != '0;
    assign idle_base = (tick.last_rx_ms > tick.last_tx_ms) ? tick.last_rx_ms : tick.last_tx_ms;
    assign ack_seen  = (tick.last_pong_ms > tick.last_rx_ms) ? tick.last_pong_ms
                                                             : tick.last_rx_ms;
    assign new_stamp = (tick.sent_ping_ms != '0) ? tick.sent_ping_ms : tick.now_ms;
    assign idle_hit  = (idle_base != '0) && elapsed(tick.now_ms, idle_base, cfg.interval_ms);
    assign rx_stale  = (tick.last_rx_ms != '0)
                       && elapsed(tick.now_ms, tick.last_rx_ms, cfg.stale_ms);

    always_comb
    begin
        st_next   = st;
        res       = '0;
        want_ping = 1'b0;
        ack_late  = 1'b0;
        if (!tick.connected)
        begin
            st_next = '0;
        end
        else
        begin
            if (enabled)
            begin
                if (cfg.connect_ping_en && !st.connect_ping_done)
                begin
                    want_ping                 = 1'b1;
                    st_next.connect_ping_done = 1'b1;
                end
                else
                begin
                    want_ping = idle_hit;
                end
            end
            if (want_ping)
            begin
                res.ping_request = 1'b1;
                if (!tick.send_ok)
                begin
                    res.ping_failed = 1'b1;
                    if (cfg.force_reconnect && !st_next.stale_reported)
                    begin
                        st_next.stale_reported = 1'b1;
                        res.stale_event        = 1'b1;
                        res.stale_reason       = REASON_SEND_FAILED;
                    end
                end
                else
                begin
                    st_next.awaiting_ack        = 1'b1;
                    st_next.stale_reported      = 1'b0;
                    st_next.expected_ping_stamp = new_stamp;
                end
            end
            if (enabled && st_next.awaiting_ack && (st_next.expected_ping_stamp != '0))
            begin
                if (ack_seen >= st_next.expected_ping_stamp)
                begin
                    st_next.awaiting_ack = 1'b0;
                end
                else
                begin
                    ack_late = elapsed(tick.now_ms, st_next.expected_ping_stamp,
                                       cfg.ack_window_ms);
                    if (cfg.force_reconnect && ack_late && !st_next.stale_reported)
                    begin
                        st_next.stale_reported = 1'b1;
                        res.stale_event        = 1'b1;
                        res.stale_reason       = REASON_ACK_TIMEOUT;
                    end
                end
            end
            if (enabled && cfg.force_reconnect && rx_stale && !st_next.stale_reported)
            begin
                st_next.stale_reported = 1'b1;
                res.stale_event        = 1'b1;
                res.stale_reason       = REASON_RX_STALE;
            end
            if ((tick.last_ping_ms != '0) && (tick.last_pong_ms >= tick.last_ping_ms))
            begin
                st_next.awaiting_ack        = 1'b0;
                st_next.stale_reported      = 1'b0;
                st_next.expected_ping_stamp = '0;
            end
        end
    end

endmodule

[rtl/link_keepalive_watchdog.sv]
// Link keepalive watchdog top level: tick register, decision logic, result register.
// An accepted tick is held in the tick register, and its result is loaded into the result
// register once that register is empty or being taken (2 register stages).
// Throughput: one tick per cycle; the only stall comes from a held result register.
// Reset (rst_n, async, active low) clears the pipeline, the watch state and
// loads register defaults. Uses lkw_pkg, lkw_regs and lkw_step.
module link_keepalive_watchdog
    import lkw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     tick_valid,
    output logic                     tick_stall,
    input  tick_t                    tick,
    output logic                     result_valid,
    input  logic                     result_stall,
    output result_t                  result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    tick_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    logic    advance;

    lkw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lkw_step u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .tick    (tick_reg),
        .res     (result_next),
        .st_next (state_next)
    );

    assign advance      = tick_valid_reg && (!result_valid_reg || !result_stall);
    assign tick_stall   = tick_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (tick_valid && !tick_stall)
            begin
                tick_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                tick_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                state_reg        <= state_next;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && !tick_stall)
        begin
            tick_reg <= tick;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.stale_event |-> result.stale_reason == REASON_ACK_TIMEOUT)
        else $error("stale_reason set without stale_event");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.ping_failed |-> result.ping_request)
        else $error("ping_failed without ping_request");

    assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> result_valid && result_stall)
        else $error("tick stalled while result register free");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !tick_reg.connected |=>
            !state_reg.awaiting_ack && !state_reg.stale_reported
            && !state_reg.connect_ping_done && (state_reg.expected_ping_stamp == '0))
        else $error("watch state not cleared on disconnect");

endmodule
